[hw/rtl/lnr_pkg.sv]
package lnr_pkg;

    localparam int CUR_W      = 14;
    localparam int DST_W      = 10;
    localparam int MW_W       = 6;
    localparam int NC_W       = 11;
    localparam int LG_W       = 4;
    localparam int DIV_DW     = 14;
    localparam int DIV_RW     = 11;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_DW / DIV_STEPS;

    localparam logic [NC_W-1:0] MAX_NODES = 11'd1024;
    localparam logic [MW_W-1:0] MAX_WIDTH = 6'd32;

    typedef enum logic [1:0] {
        CFG_TOPOLOGY   = 2'd0,
        CFG_MESH_WIDTH = 2'd1,
        CFG_NODE_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TOPO_MESH2D    = 2'd0,
        TOPO_MESH3D    = 2'd1,
        TOPO_OMEGA     = 2'd2,
        TOPO_BUTTERFLY = 2'd3
    } topo_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SAME   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_NOLINK = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        DIR_EAST  = 3'd0,
        DIR_WEST  = 3'd1,
        DIR_SOUTH = 3'd2,
        DIR_NORTH = 3'd3,
        DIR_UP    = 3'd4,
        DIR_DOWN  = 3'd5,
        DIR_PORT  = 3'd6
    } dir_t;

    typedef struct packed {
        topo_t              topo;
        logic [MW_W-1:0]    w;
        logic [LG_W-1:0]    lg;
        logic [CUR_W-1:0]   cur;
        logic [DST_W-1:0]   dst;
        status_t            early;
        logic               sw;
        logic               half_zero;
        logic [DIV_DW-1:0]  q1a;
        logic [DIV_RW-1:0]  r1a;
        logic [DIV_DW-1:0]  q1b;
        logic [DIV_RW-1:0]  r1b;
    } ctx_t;

    typedef struct packed {
        logic [DIV_RW-1:0] rem;
        logic [DIV_DW-1:0] dvd;
    } dstep_t;

    function automatic dstep_t div_step(input logic [DIV_RW-1:0] rem,
                                        input logic [DIV_DW-1:0] dvd,
                                        input logic [DIV_RW-1:0] d);
        logic [DIV_RW:0] t;
        dstep_t r;
        r.rem = rem;
        r.dvd = dvd;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {r.rem, r.dvd[DIV_DW-1]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                r.dvd = {r.dvd[DIV_DW-2:0], 1'b1};
            end else begin
                r.dvd = {r.dvd[DIV_DW-2:0], 1'b0};
            end
            r.rem = t[DIV_RW-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/interconnect_next_link_router.sv]
// From an accepted input beat to its result beat, the path runs through a set-up
// register, two seven-stage divider pipelines, and the output register.
// Throughput is one beat per cycle; the whole pipeline holds while a result
// beat waits at the output. Reset is synchronous and active low: it empties
// the pipeline and sets topology to 2D mesh, mesh width to 1 and node count to 1.
module interconnect_next_link_router (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [13:0]  s_current_id,
    input  logic [9:0]   s_dest_node,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_status,
    output logic [2:0]   m_dir_code,
    output logic [4:0]   m_link_stage,
    output logic [10:0]  m_link_index,
    output logic [6:0]   m_link_sub,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data
);

    lnr_pkg::topo_t               topology_reg;
    logic [lnr_pkg::MW_W-1:0]     mesh_width_reg;
    logic [lnr_pkg::NC_W-1:0]     node_count_reg;
    logic                         en;
    logic                         f_valid, r1_valid, r2_valid;
    lnr_pkg::ctx_t                f_ctx, r1_ctx, mid_ctx, r2_ctx;
    logic [lnr_pkg::DIV_RW-1:0]   f_d;
    logic [lnr_pkg::DIV_DW-1:0]   f_a, f_b;
    logic [lnr_pkg::DIV_DW-1:0]   q1a, q1b, q2a, q2b;
    logic [lnr_pkg::DIV_RW-1:0]   r1a, r1b, r2a, r2b;

    assign cfg_ready = 1'b1;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            topology_reg <= lnr_pkg::TOPO_MESH2D;
            mesh_width_reg <= lnr_pkg::MW_W'(1);
            node_count_reg <= lnr_pkg::NC_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                lnr_pkg::CFG_TOPOLOGY: begin
                    topology_reg <= lnr_pkg::topo_t'(cfg_data[1:0]);
                end
                lnr_pkg::CFG_MESH_WIDTH: begin
                    mesh_width_reg <= cfg_data[lnr_pkg::MW_W-1:0];
                end
                lnr_pkg::CFG_NODE_COUNT: begin
                    node_count_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    lnr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .cur        (s_current_id),
        .dst        (s_dest_node),
        .topo       (topology_reg),
        .mesh_width (mesh_width_reg),
        .node_count (node_count_reg),
        .out_valid  (f_valid),
        .out_ctx    (f_ctx),
        .out_d      (f_d),
        .out_a      (f_a),
        .out_b      (f_b)
    );

    lnr_div u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_ctx    (f_ctx),
        .in_d      (f_d),
        .in_a      (f_a),
        .in_b      (f_b),
        .out_valid (r1_valid),
        .out_ctx   (r1_ctx),
        .out_qa    (q1a),
        .out_ra    (r1a),
        .out_qb    (q1b),
        .out_rb    (r1b)
    );

    always_comb begin
        mid_ctx = r1_ctx;
        mid_ctx.q1a = q1a;
        mid_ctx.r1a = r1a;
        mid_ctx.q1b = q1b;
        mid_ctx.r1b = r1b;
    end

    lnr_div u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r1_valid),
        .in_ctx    (mid_ctx),
        .in_d      (lnr_pkg::DIV_RW'(r1_ctx.w)),
        .in_a      (q1a),
        .in_b      (q1b),
        .out_valid (r2_valid),
        .out_ctx   (r2_ctx),
        .out_qa    (q2a),
        .out_ra    (r2a),
        .out_qb    (q2b),
        .out_rb    (r2b)
    );

    lnr_route u_route (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (r2_valid),
        .ctx        (r2_ctx),
        .q2a        (q2a),
        .r2a        (r2a),
        .q2b        (q2b),
        .r2b        (r2b),
        .out_valid  (m_valid),
        .out_status (m_status),
        .out_dir    (m_dir_code),
        .out_stage  (m_link_stage),
        .out_index  (m_link_index),
        .out_sub    (m_link_sub)
    );

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != lnr_pkg::ST_OK) |->
        (m_dir_code == '0 && m_link_stage == '0 && m_link_index == '0 && m_link_sub == '0))
        else $error("non-ok result carries a link");
    a_port_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dir_code == lnr_pkg::DIR_PORT) |-> (m_link_sub == '0))
        else $error("switch port result has a third coordinate");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");
`endif

endmodule

[hw/rtl/lnr_front.sv]
module lnr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [lnr_pkg::CUR_W-1:0]    cur,
    input  logic [lnr_pkg::DST_W-1:0]    dst,
    input  lnr_pkg::topo_t               topo,
    input  logic [lnr_pkg::MW_W-1:0]     mesh_width,
    input  logic [lnr_pkg::NC_W-1:0]     node_count,
    output logic                         out_valid,
    output lnr_pkg::ctx_t                out_ctx,
    output logic [lnr_pkg::DIV_RW-1:0]   out_d,
    output logic [lnr_pkg::DIV_DW-1:0]   out_a,
    output logic [lnr_pkg::DIV_DW-1:0]   out_b
);

    logic                         valid_reg;
    lnr_pkg::ctx_t                ctx_reg, ctx_next;
    logic [lnr_pkg::DIV_RW-1:0]   d_reg, d_next;
    logic [lnr_pkg::DIV_DW-1:0]   a_reg, a_next;
    logic [lnr_pkg::DIV_DW-1:0]   b_reg, b_next;
    logic [lnr_pkg::NC_W-1:0]     n;
    logic [lnr_pkg::MW_W-1:0]     w;

    always_comb begin
        n = (node_count > lnr_pkg::MAX_NODES) ? lnr_pkg::MAX_NODES : node_count;
        if (mesh_width == '0) begin
            w = lnr_pkg::MW_W'(1);
        end else if (mesh_width > lnr_pkg::MAX_WIDTH) begin
            w = lnr_pkg::MAX_WIDTH;
        end else begin
            w = mesh_width;
        end
        ctx_next = '0;
        ctx_next.topo = topo;
        ctx_next.w = w;
        ctx_next.cur = cur;
        ctx_next.dst = dst;
        for (int i = 0; i < lnr_pkg::NC_W; i++) begin
            if (n[i]) begin
                ctx_next.lg = lnr_pkg::LG_W'(i);
            end
        end
        if (lnr_pkg::NC_W'(dst) >= n) begin
            ctx_next.early = lnr_pkg::ST_RANGE;
        end else if (cur == lnr_pkg::CUR_W'(dst)) begin
            ctx_next.early = lnr_pkg::ST_SAME;
        end else begin
            ctx_next.early = lnr_pkg::ST_OK;
        end
        ctx_next.sw = cur >= lnr_pkg::CUR_W'(n);
        ctx_next.half_zero = (n >> 1) == '0;
        a_next = cur;
        b_next = lnr_pkg::DIV_DW'(dst);
        case (topo)
            lnr_pkg::TOPO_MESH2D, lnr_pkg::TOPO_MESH3D: begin
                d_next = lnr_pkg::DIV_RW'(w);
            end
            lnr_pkg::TOPO_OMEGA: begin
                d_next = n >> 1;
                a_next = cur - lnr_pkg::CUR_W'(n);
            end
            default: begin
                d_next = n;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg <= ctx_next;
            d_reg <= d_next;
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctx = ctx_reg;
    assign out_d = d_reg;
    assign out_a = a_reg;
    assign out_b = b_reg;

endmodule

[hw/rtl/lnr_div.sv]
module lnr_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  lnr_pkg::ctx_t                in_ctx,
    input  logic [lnr_pkg::DIV_RW-1:0]   in_d,
    input  logic [lnr_pkg::DIV_DW-1:0]   in_a,
    input  logic [lnr_pkg::DIV_DW-1:0]   in_b,
    output logic                         out_valid,
    output lnr_pkg::ctx_t                out_ctx,
    output logic [lnr_pkg::DIV_DW-1:0]   out_qa,
    output logic [lnr_pkg::DIV_RW-1:0]   out_ra,
    output logic [lnr_pkg::DIV_DW-1:0]   out_qb,
    output logic [lnr_pkg::DIV_RW-1:0]   out_rb
);

    localparam int S = lnr_pkg::DIV_STAGES;

    logic                         valid_reg [S];
    lnr_pkg::ctx_t                ctx_reg   [S];
    logic [lnr_pkg::DIV_RW-1:0]   d_reg     [S];
    logic [lnr_pkg::DIV_RW-1:0]   ra_reg    [S];
    logic [lnr_pkg::DIV_DW-1:0]   qa_reg    [S];
    logic [lnr_pkg::DIV_RW-1:0]   rb_reg    [S];
    logic [lnr_pkg::DIV_DW-1:0]   qb_reg    [S];

    for (genvar s = 0; s < S; s++) begin : g_stage
        logic                         v_in;
        lnr_pkg::ctx_t                c_in;
        logic [lnr_pkg::DIV_RW-1:0]   d_in;
        lnr_pkg::dstep_t              step_a;
        lnr_pkg::dstep_t              step_b;

        if (s == 0) begin : g_first
            assign v_in = in_valid;
            assign c_in = in_ctx;
            assign d_in = in_d;
            assign step_a = lnr_pkg::div_step({lnr_pkg::DIV_RW{1'b0}}, in_a, in_d);
            assign step_b = lnr_pkg::div_step({lnr_pkg::DIV_RW{1'b0}}, in_b, in_d);
        end else begin : g_next
            assign v_in = valid_reg[s-1];
            assign c_in = ctx_reg[s-1];
            assign d_in = d_reg[s-1];
            assign step_a = lnr_pkg::div_step(ra_reg[s-1], qa_reg[s-1], d_reg[s-1]);
            assign step_b = lnr_pkg::div_step(rb_reg[s-1], qb_reg[s-1], d_reg[s-1]);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_reg[s] <= c_in;
                d_reg[s] <= d_in;
                ra_reg[s] <= step_a.rem;
                qa_reg[s] <= step_a.dvd;
                rb_reg[s] <= step_b.rem;
                qb_reg[s] <= step_b.dvd;
            end
        end
    end

    assign out_valid = valid_reg[S-1];
    assign out_ctx = ctx_reg[S-1];
    assign out_qa = qa_reg[S-1];
    assign out_ra = ra_reg[S-1];
    assign out_qb = qb_reg[S-1];
    assign out_rb = rb_reg[S-1];

endmodule

[hw/rtl/lnr_route.sv]
module lnr_route (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  lnr_pkg::ctx_t                ctx,
    input  logic [lnr_pkg::DIV_DW-1:0]   q2a,
    input  logic [lnr_pkg::DIV_RW-1:0]   r2a,
    input  logic [lnr_pkg::DIV_DW-1:0]   q2b,
    input  logic [lnr_pkg::DIV_RW-1:0]   r2b,
    output logic                         out_valid,
    output logic [1:0]                   out_status,
    output logic [2:0]                   out_dir,
    output logic [4:0]                   out_stage,
    output logic [10:0]                  out_index,
    output logic [6:0]                   out_sub
);

    logic              valid_reg;
    lnr_pkg::status_t  status_reg, status_next;
    lnr_pkg::dir_t     dir_reg, dir_next;
    logic [4:0]        stage_reg;
    logic [10:0]       index_reg;
    logic [6:0]        sub_reg;
    logic [15:0]       wv, sx, sy, sz, dx, dy, dz, a, b, c, col, row, dstv;
    logic [3:0]        sh;
    logic              ok;

    always_comb begin
        wv = 16'(ctx.w);
        dstv = 16'(ctx.dst);
        sx = 16'(ctx.r1a);
        dx = 16'(ctx.r1b);
        sy = 16'(ctx.q1a);
        dy = 16'(ctx.q1b);
        sz = 16'(q2a);
        dz = 16'(q2b);
        col = '0;
        row = 16'(ctx.r1a);
        sh = '0;
        a = '0;
        b = '0;
        c = '0;
        ok = 1'b1;
        dir_next = lnr_pkg::DIR_EAST;
        status_next = ctx.early;
        case (ctx.topo)
            lnr_pkg::TOPO_MESH2D: begin
                if (dx != sx) begin
                    if (dx > sx) begin
                        dir_next = lnr_pkg::DIR_EAST;
                        a = sx;
                    end else begin
                        dir_next = lnr_pkg::DIR_WEST;
                        a = sx - 16'd1;
                    end
                    b = sy;
                end else if (dy != sy) begin
                    if (dy > sy) begin
                        dir_next = lnr_pkg::DIR_SOUTH;
                        a = sy;
                    end else begin
                        dir_next = lnr_pkg::DIR_NORTH;
                        a = sy - 16'd1;
                    end
                    b = sx + wv;
                end else if (status_next == lnr_pkg::ST_OK) begin
                    status_next = lnr_pkg::ST_SAME;
                end
                ok = (a < wv - 16'd1) && (b < (wv << 1));
            end
            lnr_pkg::TOPO_MESH3D: begin
                sy = 16'(r2a);
                dy = 16'(r2b);
                if (dx != sx) begin
                    if (dx > sx) begin
                        dir_next = lnr_pkg::DIR_EAST;
                        a = sx;
                    end else begin
                        dir_next = lnr_pkg::DIR_WEST;
                        a = sx - 16'd1;
                    end
                    b = sy;
                    c = sz;
                end else if (dy != sy) begin
                    if (dy > sy) begin
                        dir_next = lnr_pkg::DIR_SOUTH;
                        a = sy;
                    end else begin
                        dir_next = lnr_pkg::DIR_NORTH;
                        a = sy - 16'd1;
                    end
                    b = sz;
                    c = sx + wv;
                end else if (dz != sz) begin
                    if (dz > sz) begin
                        dir_next = lnr_pkg::DIR_UP;
                        a = sz;
                    end else begin
                        dir_next = lnr_pkg::DIR_DOWN;
                        a = sz - 16'd1;
                    end
                    b = sx;
                    c = sy + (wv << 1);
                end else if (status_next == lnr_pkg::ST_OK) begin
                    status_next = lnr_pkg::ST_SAME;
                end
                ok = (a < wv - 16'd1) && (b < wv) && (c < wv + (wv << 1));
            end
            lnr_pkg::TOPO_OMEGA: begin
                dir_next = lnr_pkg::DIR_PORT;
                if (!ctx.sw) begin
                    b = 16'(ctx.cur);
                end else if (ctx.half_zero) begin
                    ok = 1'b0;
                end else begin
                    col = sy + 16'd1;
                    ok = col <= 16'(ctx.lg);
                    sh = ctx.lg - col[3:0];
                    a = col;
                    b = (row << 1) + ((dstv >> sh) & 16'd1);
                end
            end
            default: begin
                dir_next = lnr_pkg::DIR_PORT;
                col = sy;
                ok = col < 16'(ctx.lg);
                sh = ctx.lg - col[3:0] - 4'd1;
                a = col;
                b = (row << 1) + ((dstv >> sh) & 16'd1);
            end
        endcase
        if (status_next == lnr_pkg::ST_OK && !ok) begin
            status_next = lnr_pkg::ST_NOLINK;
        end
        if (status_next != lnr_pkg::ST_OK) begin
            dir_next = lnr_pkg::DIR_EAST;
            a = '0;
            b = '0;
            c = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= status_next;
            dir_reg <= dir_next;
            stage_reg <= a[4:0];
            index_reg <= b[10:0];
            sub_reg <= c[6:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_status = status_reg;
    assign out_dir = dir_reg;
    assign out_stage = stage_reg;
    assign out_index = index_reg;
    assign out_sub = sub_reg;

endmodule
